>>> rtl/atma_pkg.sv
// ---------------------------------------------------------------------------
// atma_pkg: shared types and constants for the trimmed-mean averager
// Field widths, window constants and the per-channel state record.
// ---------------------------------------------------------------------------
package atma_pkg;

    // Field widths
    localparam int CHANNEL_W = 5;
    localparam int SAMPLE_W  = 10;
    localparam int SUM_W     = 15;
    localparam int COUNT_W   = 5;
    localparam int SMALL_W   = 11;
    localparam int TDATA_W   = 16;

    // Channel count default and the reachable channel range
    localparam int CHANNELS_DEF  = 32;
    localparam int CHANNEL_SPACE = 1 << CHANNEL_W;

    // Window handling: 22 samples, min and max dropped, the other 20 averaged
    localparam logic [COUNT_W-1:0] WINDOW_LEN     = COUNT_W'(22);
    localparam logic [SMALL_W-1:0] SMALLEST_RESET = SMALL_W'(1024);
    localparam logic [SAMPLE_W-1:0] AVERAGE_MAX   = '1;

    // Divide by 20: shift right by two, then multiply by ceil(2^14 / 5).
    // Exact for every quotient input below 2^14.
    localparam int DIV4_SHIFT   = 2;
    localparam int DIV5_SHIFT   = 14;
    localparam int DIV5_RECIP_W = 12;
    localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP =
        DIV5_RECIP_W'(((1 << DIV5_SHIFT) + 4) / 5);

    // Per-channel state record
    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [COUNT_W-1:0]  count;
        logic [SAMPLE_W-1:0] largest;
        logic [SMALL_W-1:0]  smallest;
        logic [SAMPLE_W-1:0] held;
    } t_chan_state;

    localparam t_chan_state STATE_RESET = '{
        sum:      '0,
        count:    '0,
        largest:  '0,
        smallest: SMALLEST_RESET,
        held:     '0
    };

endpackage

>>> rtl/atma_update.sv
// ---------------------------------------------------------------------------
// atma_update: per-sample channel state update
// Folds one sample into a channel record and closes the window on the
// 22nd sample with the trimmed mean (sum - max - min) / 20.
// ---------------------------------------------------------------------------
module atma_update
    import atma_pkg::*;
(
    input  t_chan_state         i_cur,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_chan_state         o_nxt,
    output logic [SAMPLE_W-1:0] o_average,
    output logic                o_updated
);

    localparam int DROP_W = SMALL_W + 1;
    localparam int X_W    = SUM_W - DIV4_SHIFT;
    localparam int PROD_W = X_W + DIV5_RECIP_W;
    localparam int Q_W    = PROD_W - DIV5_SHIFT;

    logic [SAMPLE_W-1:0] largest_n;
    logic [SMALL_W-1:0]  smallest_n;
    logic [SUM_W-1:0]    sum_n;
    logic [COUNT_W-1:0]  count_n;
    logic [DROP_W-1:0]   drop;
    logic [SUM_W-1:0]    kept;
    logic [X_W-1:0]      quarter;
    logic [PROD_W-1:0]   prod;
    logic [Q_W-1:0]      quot;
    logic [SAMPLE_W-1:0] avg_new;

    // Track extremes, accumulate, advance the count
    always_comb begin
        largest_n  = (i_sample > i_cur.largest) ? i_sample : i_cur.largest;
        smallest_n = (SMALL_W'(i_sample) < i_cur.smallest) ? SMALL_W'(i_sample)
                                                           : i_cur.smallest;
        sum_n      = i_cur.sum + SUM_W'(i_sample);
        count_n    = i_cur.count + COUNT_W'(1);
        o_updated  = (count_n >= WINDOW_LEN);
    end

    // Trimmed mean: drop both extremes, divide by 20
    always_comb begin
        drop    = DROP_W'(largest_n) + DROP_W'(smallest_n);
        kept    = (SUM_W'(drop) <= sum_n) ? sum_n - SUM_W'(drop) : '0;
        quarter = kept[SUM_W-1:DIV4_SHIFT];
        prod    = PROD_W'(quarter) * PROD_W'(DIV5_RECIP);
        quot    = prod[PROD_W-1:DIV5_SHIFT];
        avg_new = (quot > Q_W'(AVERAGE_MAX)) ? AVERAGE_MAX : quot[SAMPLE_W-1:0];
    end

    // Close the window or carry the running values
    always_comb begin
        if (o_updated) begin
            o_nxt      = STATE_RESET;
            o_nxt.held = avg_new;
        end else begin
            o_nxt.sum      = sum_n;
            o_nxt.count    = count_n;
            o_nxt.largest  = largest_n;
            o_nxt.smallest = smallest_n;
            o_nxt.held     = i_cur.held;
        end
        o_average = o_nxt.held;
    end

endmodule

>>> rtl/atma_chan_store.sv
// ---------------------------------------------------------------------------
// atma_chan_store: per-channel state registers
// One state record per channel, read at one index, written at one index.
// ---------------------------------------------------------------------------
module atma_chan_store
    import atma_pkg::*;
#(
    parameter int DEPTH = CHANNELS_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_chan_state      o_rd_state,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_chan_state      i_wr_state
);

    t_chan_state r_state [DEPTH];

    // Read the addressed record
    assign o_rd_state = r_state[i_rd_idx];

    // Clear every record at reset, write back the updated record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_state[i] <= STATE_RESET;
            end
        end else if (i_wr_en) begin
            r_state[i_wr_idx] <= i_wr_state;
        end
    end

endmodule

>>> rtl/adc_trimmed_mean_averager_core.sv
// ---------------------------------------------------------------------------
// adc_trimmed_mean_averager_core: per-channel trimmed-mean averager
// Accumulates converter samples per channel and every 22 samples holds the
// mean of the 20 left after dropping one maximum and one minimum.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one request per sample: channel and 10-bit sample.
//   Master stream returns one result per request: the echoed channel, the
//   channel's held average after this sample, and in tuser a flag that is
//   set when this sample closed a 22-sample window.
//   Channels at or above CHANNELS change nothing and return average 0.
//   One input register, then the state update and the result register.
//   One request is taken every cycle while the receiver does not stall;
//   the channel state is updated in the same cycle the result is
//   registered, so back-to-back samples of one channel see each other.
//   When the receiver stalls, the result register holds and one more
//   request may still be taken into the input register; after that tready
//   follows the receiver.
//   Reset clears all channel state (sums, counts, extremes, held averages)
//   and empties both registers.
// ---------------------------------------------------------------------------
module adc_trimmed_mean_averager_core
    import atma_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // [4:0] channel, [14:5] sample, [15] zero
    input  logic [TDATA_W-1:0] i_s_axis_tdata,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [4:0] result_channel, [14:5] average, [15] zero
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    // [0] updated
    output logic [0:0]         o_m_axis_tuser
);

    localparam int DEPTH = (CHANNELS < CHANNEL_SPACE) ? CHANNELS : CHANNEL_SPACE;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 r_in_valid;
    logic [CHANNEL_W-1:0] r_in_channel;
    logic [SAMPLE_W-1:0]  r_in_sample;
    logic                 r_out_valid;
    logic [CHANNEL_W-1:0] r_out_channel;
    logic [SAMPLE_W-1:0]  r_out_average;
    logic                 r_out_updated;

    logic                 advance;
    logic                 in_range;
    logic [IDX_W-1:0]     idx;
    t_chan_state          cur_state;
    t_chan_state          nxt_state;
    logic [SAMPLE_W-1:0]  new_average;
    logic                 new_updated;

    // Move the input stage on when the result register is free or drained
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;

    assign in_range = (32'(r_in_channel) < CHANNELS);
    assign idx      = in_range ? r_in_channel[IDX_W-1:0] : '0;

    atma_chan_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (idx),
        .o_rd_state (cur_state),
        .i_wr_en    (r_in_valid && advance && in_range),
        .i_wr_idx   (idx),
        .i_wr_state (nxt_state)
    );

    atma_update u_update (
        .i_cur     (cur_state),
        .i_sample  (r_in_sample),
        .o_nxt     (nxt_state),
        .o_average (new_average),
        .o_updated (new_updated)
    );

    // Input register: take a request whenever the stage is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_channel <= i_s_axis_tdata[CHANNEL_W-1:0];
            r_in_sample  <= i_s_axis_tdata[CHANNEL_W +: SAMPLE_W];
        end
    end

    // Result register: load on advance, hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_channel <= r_in_channel;
            r_out_average <= in_range ? new_average : '0;
            r_out_updated <= in_range && new_updated;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'({r_out_average, r_out_channel});
    assign o_m_axis_tuser  = r_out_updated;

endmodule
